@@ rtl/assert_macros.svh @@
// Assertion helpers for the tokenizer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define STT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sttok_pkg.sv @@
package sttok_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int EXT_BITS    = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int MAX_PUSH    = 3;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    localparam offset_t OFFSET_MAX = '1;

    typedef enum logic [3:0] {
        TK_LBRACE = 4'd0,
        TK_RBRACE = 4'd1,
        TK_COMMA  = 4'd2,
        TK_COLON  = 4'd3,
        TK_STAR   = 4'd4,
        TK_STRING = 4'd5,
        TK_INT    = 4'd6,
        TK_FLOAT  = 4'd7,
        TK_IDENT  = 4'd8,
        TK_EOF    = 4'd9
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_IDENT  = 2'd3
    } lex_mode_t;

    typedef struct packed {
        token_kind_t kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } push_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    function automatic offset_t sat_inc(offset_t v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + offset_t'(1);
    endfunction

    function automatic logic [31:0] clip32(offset_t v);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v);
        if (ext > EXT_BITS'(33'h0_FFFF_FFFF))
            return 32'hFFFF_FFFF;
        return ext[31:0];
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_float_mark(logic [7:0] b);
        return (b == CH_DOT) || (b == CH_LOW_E) || (b == CH_UP_E);
    endfunction

    function automatic logic is_num_cont(logic [7:0] b);
        return is_digit(b) || is_float_mark(b) || (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

    function automatic logic is_ident_cont(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_USCORE) || (b == CH_DOT)
            || (b == CH_MINUS);
    endfunction

endpackage

@@ rtl/sttok_lex.sv @@
module sttok_lex (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output sttok_pkg::push_t    push
);
    import sttok_pkg::*;

    lex_mode_t mode_reg, mode_next;
    logic      fms_reg, fms_next;
    offset_t   begin_reg, begin_next;
    offset_t   pos_reg, pos_next;

    logic      relex;
    logic      close_open;
    offset_t   end_pos;

    // Open token is closed by this byte, relex decides whether the byte starts anew.
    always_comb
    begin
        relex      = 1'b1;
        close_open = 1'b0;
        unique case (mode_reg)
            MODE_STRING:
            begin
                relex      = 1'b0;
                close_open = (data_byte == CH_QUOTE);
            end
            MODE_NUMBER:
            begin
                relex      = !is_num_cont(data_byte);
                close_open = relex;
            end
            MODE_IDENT:
            begin
                relex      = !is_ident_cont(data_byte);
                close_open = relex;
            end
            default:
            begin
                relex      = 1'b1;
                close_open = 1'b0;
            end
        endcase
    end

    assign end_pos = sat_inc(pos_reg);

    // next state
    always_comb
    begin
        mode_next  = close_open ? MODE_IDLE : mode_reg;
        fms_next   = fms_reg;
        begin_next = begin_reg;
        if ((mode_reg == MODE_NUMBER) && !relex && is_float_mark(data_byte))
            fms_next = 1'b1;
        if (relex)
        begin
            if (data_byte == CH_QUOTE)
            begin
                mode_next  = MODE_STRING;
                begin_next = end_pos;
            end
            else if ((data_byte == CH_MINUS) || is_digit(data_byte))
            begin
                mode_next  = MODE_NUMBER;
                fms_next   = 1'b0;
                begin_next = pos_reg;
            end
            else if (is_alpha(data_byte) || (data_byte == CH_USCORE))
            begin
                mode_next  = MODE_IDENT;
                begin_next = pos_reg;
            end
        end
        pos_next = end_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            fms_reg   <= 1'b0;
            begin_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                mode_reg  <= MODE_IDLE;
                fms_reg   <= 1'b0;
                begin_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                fms_reg   <= fms_next;
                begin_reg <= begin_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // outputs: up to four candidates in order, compacted to three slots
    result_t     cand [4];
    logic [3:0]  cand_v;
    logic [1:0]  slot;
    token_kind_t single_kind;
    logic        single_v;

    always_comb
    begin
        single_v    = 1'b1;
        single_kind = TK_LBRACE;
        unique case (data_byte)
            CH_LBRACE: single_kind = TK_LBRACE;
            CH_RBRACE: single_kind = TK_RBRACE;
            CH_COMMA:  single_kind = TK_COMMA;
            CH_COLON:  single_kind = TK_COLON;
            CH_STAR:   single_kind = TK_STAR;
            default:   single_v    = 1'b0;
        endcase
    end

    always_comb
    begin
        cand[0].kind   = (mode_reg == MODE_STRING) ? TK_STRING :
                         (mode_reg == MODE_NUMBER) ? (fms_reg ? TK_FLOAT : TK_INT) :
                         TK_IDENT;
        cand[0].start  = clip32(begin_reg);
        cand[0].length = clip32(pos_reg - begin_reg);
        cand[0].last   = 1'b0;
        cand_v[0]      = close_open;

        cand[1].kind   = single_kind;
        cand[1].start  = clip32(pos_reg);
        cand[1].length = 32'd1;
        cand[1].last   = 1'b0;
        cand_v[1]      = relex && single_v;

        cand[2].kind   = (mode_next == MODE_STRING) ? TK_STRING :
                         (mode_next == MODE_NUMBER) ? (fms_next ? TK_FLOAT : TK_INT) :
                         TK_IDENT;
        cand[2].start  = clip32(begin_next);
        cand[2].length = clip32(end_pos - begin_next);
        cand[2].last   = 1'b0;
        cand_v[2]      = final_byte && (mode_next != MODE_IDLE);

        cand[3].kind   = TK_EOF;
        cand[3].start  = clip32(end_pos);
        cand[3].length = 32'd0;
        cand[3].last   = 1'b1;
        cand_v[3]      = final_byte;

        cand[0].last   = !final_byte && !cand_v[1];
        cand[1].last   = !final_byte;
    end

    always_comb
    begin
        push.res   = '0;
        slot       = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && (slot != 2'd3))
            begin
                push.res[slot] = cand[i];
                slot           = slot + 2'd1;
            end
        end
        push.count = slot;
    end

endmodule

@@ rtl/sttok_fifo.sv @@
module sttok_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  sttok_pkg::push_t    push,
    output logic                space_ok,
    output logic                head_valid,
    input  logic                pop,
    output sttok_pkg::result_t  head
);
    import sttok_pkg::*;

    result_t              buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic [1:0]           n_push;
    logic                 do_pop;

    assign n_push     = push_en ? push.count : 2'd0;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign space_ok   = (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_PUSH));
    assign head       = buf_reg[rd_ptr_reg];
    assign cnt_next   = cnt_reg + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(n_push);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (2'(i) < n_push)
                buf_reg[wr_ptr_reg + FIFO_AW'(i)] <= push.res[i];
        end
    end

endmodule

@@ rtl/scene_text_tokenizer.sv @@
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | data_byte, final_byte
// out     | out_valid / out_ready| token_kind, token_start, token_length, run_last
//
// One byte is taken per cycle while in_ready is high; the lexer state updates in that cycle and the
// byte's zero to three tokens land in an eight-word result queue.
// Token words are registered into the queue; it drains one word a cycle while out_ready is high.
// in_ready drops while the queue holds more than five words.
// rst_n clears the lexer state and empties the queue; the final byte does the same to the lexer.
module scene_text_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic        run_last
);
    import sttok_pkg::*;

    logic    accept;
    push_t   push;
    result_t head;

    assign accept = in_valid && in_ready;

    sttok_lex u_lex (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    sttok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (accept),
        .push       (push),
        .space_ok   (in_ready),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign run_last     = head.last;

endmodule

@@ rtl/sttok_checker.sv @@
`include "assert_macros.svh"

module sttok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind,
    input logic [31:0] token_start,
    input logic [31:0] token_length,
    input logic        run_last
);
    import sttok_pkg::*;

    logic single_kind;
    logic is_eof;

    assign single_kind = (token_kind == TK_LBRACE) || (token_kind == TK_RBRACE)
        || (token_kind == TK_COMMA) || (token_kind == TK_COLON) || (token_kind == TK_STAR);
    assign is_eof = (token_kind == TK_EOF);

    `STT_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !out_valid, "word shown during reset")
    `STT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(token_start), "stalled word")
    `STT_ASSERT(a_eof_last, out_valid && is_eof |-> run_last && (token_length == 32'd0), "bad EOF word")
    `STT_ASSERT(a_single_len, out_valid && single_kind |-> token_length == 32'd1, "punct length")

endmodule

bind scene_text_tokenizer sttok_checker u_sttok_checker (.*);
